>>> hw/rtl/utps_pkg.sv
// ----------------------------------------------------------------------------
// utps_pkg
// Shared widths, code point limits, score weights and types for the UTF-8
// text plausibility scorer.
// ----------------------------------------------------------------------------
package utps_pkg;

	localparam int CP_W    = 21;
	localparam int SCORE_W = 32;
	localparam int WGT_W   = 6;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_C1_LO       = 21'h000080;
	localparam logic [CP_W-1:0] CP_C1_HI       = 21'h00009F;
	localparam logic [CP_W-1:0] CP_HWKANA_LO   = 21'h00FF61;
	localparam logic [CP_W-1:0] CP_HWKANA_HI   = 21'h00FF9F;
	localparam logic [CP_W-1:0] CP_KANA_LO     = 21'h003040;
	localparam logic [CP_W-1:0] CP_KANA_HI     = 21'h0030FF;
	localparam logic [CP_W-1:0] CP_KANA_EXT_LO = 21'h0031F0;
	localparam logic [CP_W-1:0] CP_KANA_EXT_HI = 21'h0031FF;
	localparam logic [CP_W-1:0] CP_CJK_LO      = 21'h004E00;
	localparam logic [CP_W-1:0] CP_CJK_HI      = 21'h009FFF;
	localparam logic [CP_W-1:0] CP_PRINT_LO    = 21'h000020;
	localparam logic [CP_W-1:0] CP_PRINT_HI    = 21'h00007E;

	localparam logic signed [WGT_W-1:0] WGT_BAD    = -6'sd32;
	localparam logic signed [WGT_W-1:0] WGT_HWKANA = -6'sd8;
	localparam logic signed [WGT_W-1:0] WGT_KANA   = 6'sd6;
	localparam logic signed [WGT_W-1:0] WGT_CJK    = 6'sd2;
	localparam logic signed [WGT_W-1:0] WGT_PRINT  = 6'sd1;
	localparam logic signed [WGT_W-1:0] WGT_NONE   = 6'sd0;

	localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [CP_W-1:0] partial;
		logic [1:0]      expected;
	} dec_state_t;

	typedef struct packed {
		logic            valid;
		logic [CP_W-1:0] cp;
	} cp_event_t;

endpackage

>>> hw/rtl/utps_in_if.sv
// ----------------------------------------------------------------------------
// utps_in_if
// Byte channel of the scorer: one text byte per transfer with its marks.
// ----------------------------------------------------------------------------
interface utps_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       byte_present;
	logic       end_of_text;

	modport source (output valid, output text_byte, output byte_present,
		output end_of_text, input ready);
	modport sink (input valid, input text_byte, input byte_present,
		input end_of_text, output ready);

endinterface

>>> hw/rtl/utps_out_if.sv
// ----------------------------------------------------------------------------
// utps_out_if
// Score channel of the scorer: one final score per transfer.
// ----------------------------------------------------------------------------
interface utps_out_if;

	logic               valid;
	logic               ready;
	logic signed [31:0] final_score;

	modport source (output valid, output final_score, input ready);
	modport sink (input valid, input final_score, output ready);

endinterface

>>> hw/rtl/utps_decode.sv
// ----------------------------------------------------------------------------
// utps_decode
// Loose UTF-8 decoder step: folds one byte into the open sequence and reports
// a finished code point, including a sequence cut short at end of text.
// ----------------------------------------------------------------------------
module utps_decode import utps_pkg::*; (
	input  dec_state_t state,
	input  logic [7:0] text_byte,
	input  logic       byte_present,
	input  logic       end_of_text,
	output dec_state_t state_next,
	output cp_event_t  cp_event
);

	logic [CP_W-1:0] cont_cp;

	always_comb begin
		cont_cp    = {state.partial[CP_W-7:0], text_byte[5:0]};
		state_next = state;
		cp_event   = '0;
		if (byte_present) begin
			if (state.expected != 2'd0) begin
				state_next.expected = state.expected - 2'd1;
				if (state.expected == 2'd1) begin
					cp_event.valid     = 1'b1;
					cp_event.cp        = cont_cp;
					state_next.partial = '0;
				end else begin
					state_next.partial = cont_cp;
				end
			end else if (text_byte[7:5] == 3'b110) begin
				state_next.partial  = CP_W'(text_byte[4:0]);
				state_next.expected = 2'd1;
			end else if (text_byte[7:4] == 4'b1110) begin
				state_next.partial  = CP_W'(text_byte[3:0]);
				state_next.expected = 2'd2;
			end else if (text_byte[7:3] == 5'b11110) begin
				state_next.partial  = CP_W'(text_byte[2:0]);
				state_next.expected = 2'd3;
			end else begin
				cp_event.valid = 1'b1;
				cp_event.cp    = CP_W'(text_byte);
			end
		end
		if (end_of_text) begin
			if (state_next.expected != 2'd0) begin
				cp_event.valid = 1'b1;
				cp_event.cp    = state_next.partial;
			end
			state_next = '0;
		end
	end

endmodule

>>> hw/rtl/utps_accum.sv
// ----------------------------------------------------------------------------
// utps_accum
// Weighs a finished code point and adds the weight to the running score,
// saturating to the signed 32-bit range.
// ----------------------------------------------------------------------------
module utps_accum import utps_pkg::*; (
	input  logic signed [SCORE_W-1:0] score,
	input  cp_event_t                 cp_event,
	output logic signed [SCORE_W-1:0] score_next
);

	logic signed [WGT_W-1:0]   weight;
	logic signed [SCORE_W:0]   sum;
	logic [CP_W-1:0]           cp;

	assign cp = cp_event.cp;

	always_comb begin
		if (cp == CP_REPLACEMENT || (cp inside {[CP_C1_LO:CP_C1_HI]})) begin
			weight = WGT_BAD;
		end else if (cp inside {[CP_HWKANA_LO:CP_HWKANA_HI]}) begin
			weight = WGT_HWKANA;
		end else if (cp inside {[CP_KANA_LO:CP_KANA_HI], [CP_KANA_EXT_LO:CP_KANA_EXT_HI]}) begin
			weight = WGT_KANA;
		end else if (cp inside {[CP_CJK_LO:CP_CJK_HI]}) begin
			weight = WGT_CJK;
		end else if (cp inside {[CP_PRINT_LO:CP_PRINT_HI]}) begin
			weight = WGT_PRINT;
		end else begin
			weight = WGT_NONE;
		end
	end

	always_comb begin
		sum = (SCORE_W+1)'(score) + (SCORE_W+1)'(weight);
		if (!cp_event.valid) begin
			score_next = score;
		end else if (sum[SCORE_W] != sum[SCORE_W-1]) begin
			score_next = sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
		end else begin
			score_next = sum[SCORE_W-1:0];
		end
	end

endmodule

>>> hw/rtl/utf8_text_plausibility_scorer_core.sv
// ----------------------------------------------------------------------------
// utf8_text_plausibility_scorer_core
// Scores a UTF-8 byte stream and reports a saturated plausibility score at
// the end of each text.
// ----------------------------------------------------------------------------
// The byte channel in_ch takes one text byte per transfer together with
// byte_present and end_of_text. An item with byte_present low and
// end_of_text low changes nothing. The item with end_of_text high closes the
// text, and one transfer on out_ch then carries its final_score; the state
// clears so that the next byte starts a new text.
// Throughput is one byte per cycle while in_ch holds ready, set by the decode
// and saturating add path between the input register and the score register.
// The final score is registered as the closing item leaves the input register.
// While a score waits on out_ch, bytes of the next text keep flowing; only a
// second closing item waits in the input register until out_ch is free, and
// in_ch drops ready when that register cannot move.
// Reset empties both registers, clears the open sequence and sets the score
// to zero.
// ----------------------------------------------------------------------------
module utf8_text_plausibility_scorer_core import utps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	utps_in_if.sink     in_ch,
	utps_out_if.source  out_ch
);

	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      present_s1;
	logic                      last_s1;
	dec_state_t                state_q;
	dec_state_t                state_next;
	cp_event_t                 cp_event;
	logic signed [SCORE_W-1:0] score_q;
	logic signed [SCORE_W-1:0] score_next;
	logic                      out_valid_q;
	logic signed [SCORE_W-1:0] final_score_q;
	logic                      advance;

	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1    <= in_ch.text_byte;
			present_s1 <= in_ch.byte_present;
			last_s1    <= in_ch.end_of_text;
		end
	end

	utps_decode u_decode (
		.state        (state_q),
		.text_byte    (byte_s1),
		.byte_present (present_s1),
		.end_of_text  (last_s1),
		.state_next   (state_next),
		.cp_event     (cp_event)
	);

	utps_accum u_accum (
		.score      (score_q),
		.cp_event   (cp_event),
		.score_next (score_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			score_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
			score_q <= last_s1 ? '0 : score_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			final_score_q <= score_next;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.final_score = final_score_q;

	a_no_partial_when_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.expected == 2'd0) |-> (state_q.partial == '0))
		else $error("partial code point held with no open sequence");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> (state_q == '0 && score_q == '0 && out_valid_q))
		else $error("state not cleared or score not posted after end of text");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready && valid_s1 && last_s1) |-> !advance)
		else $error("pending final score overwritten");

endmodule

>>> dv/utf8_text_plausibility_scorer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_text_plausibility_scorer_core_tb
// Streams UTF-8 texts into the scorer and checks every final score.
// ----------------------------------------------------------------------------
// A short directed run covers empty text, idle items, stray and truncated
// sequences and each score class. Random texts follow, mostly well-formed
// code points with random content, mixed with raw bytes, broken sequences
// and idle items. The sender and receiver stall at random, and one long
// receiver stall fills the scorer with closing items. Each closing item
// scored by the local predictor queues one expected score.
// ----------------------------------------------------------------------------
module utf8_text_plausibility_scorer_core_tb import utps_pkg::*; ();

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       end_of_text;
	} text_item_t;

	logic clk;
	logic arst_n;

	utps_in_if  in_ch ();
	utps_out_if out_ch ();

	utf8_text_plausibility_scorer_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	text_item_t                  byte_queue[$];
	logic signed [SCORE_W-1:0]   score_queue[$];
	logic [CP_W-1:0]             open_cp;
	logic [1:0]                  cont_left;
	logic signed [SCORE_W-1:0]   run_score;
	int                          send_idle_pct;
	int                          recv_idle_pct;
	int                          errors;
	int                          items_made;
	int                          holds_asked;
	int                          holds_served;
	int                          hold_left;

	logic [CP_W-1:0] range_bounds[13] = '{CP_REPLACEMENT, CP_C1_LO, CP_C1_HI,
		CP_HWKANA_LO, CP_HWKANA_HI, CP_KANA_LO, CP_KANA_HI, CP_KANA_EXT_LO,
		CP_KANA_EXT_HI, CP_CJK_LO, CP_CJK_HI, CP_PRINT_LO, CP_PRINT_HI};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.text_byte = '0;
		in_ch.byte_present = 1'b0;
		in_ch.end_of_text = 1'b0;
		out_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		#2_000_000;
		$display("utf8_text_plausibility_scorer_core: mismatch");
		$finish;
	end

	function automatic int plausibility_weight(input logic [CP_W-1:0] cp);
		if (cp == CP_REPLACEMENT || (cp >= CP_C1_LO && cp <= CP_C1_HI))
			return int'(WGT_BAD);
		if (cp >= CP_HWKANA_LO && cp <= CP_HWKANA_HI)
			return int'(WGT_HWKANA);
		if ((cp >= CP_KANA_LO && cp <= CP_KANA_HI) ||
				(cp >= CP_KANA_EXT_LO && cp <= CP_KANA_EXT_HI))
			return int'(WGT_KANA);
		if (cp >= CP_CJK_LO && cp <= CP_CJK_HI)
			return int'(WGT_CJK);
		if (cp >= CP_PRINT_LO && cp <= CP_PRINT_HI)
			return int'(WGT_PRINT);
		return int'(WGT_NONE);
	endfunction

	task automatic add_weight(input logic [CP_W-1:0] cp);
		logic signed [SCORE_W:0] sum;
		sum = run_score + plausibility_weight(cp);
		if (sum > SCORE_MAX)
			run_score = SCORE_MAX;
		else if (sum < SCORE_MIN)
			run_score = SCORE_MIN;
		else
			run_score = sum[SCORE_W-1:0];
	endtask

	task automatic score_text_item(input logic [7:0] b, input logic present,
			input logic last);
		if (present) begin
			if (cont_left != 2'd0) begin
				open_cp = {open_cp[CP_W-7:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0) begin
					add_weight(open_cp);
					open_cp = '0;
				end
			end else if (b[7:5] == 3'b110) begin
				open_cp = CP_W'(b[4:0]);
				cont_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				open_cp = CP_W'(b[3:0]);
				cont_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				open_cp = CP_W'(b[2:0]);
				cont_left = 2'd3;
			end else begin
				add_weight(CP_W'(b));
			end
		end
		if (last) begin
			if (cont_left != 2'd0)
				add_weight(open_cp);
			score_queue = {score_queue, run_score};
			open_cp = '0;
			cont_left = 2'd0;
			run_score = '0;
		end
	endtask

	task automatic put_byte(input logic [7:0] b, input logic present, input logic last);
		text_item_t it;
		it.text_byte = b;
		it.byte_present = present;
		it.end_of_text = last;
		byte_queue = {byte_queue, it};
		if (present || last)
			items_made++;
	endtask

	task automatic put_code_point(input logic [CP_W-1:0] cp, input int nbytes,
			input int keep);
		logic [7:0] b;
		case (nbytes)
			2: b = {3'b110, cp[10:6]};
			3: b = {4'b1110, cp[15:12]};
			default: b = {5'b11110, cp[20:18]};
		endcase
		put_byte(b, 1'b1, 1'b0);
		for (int k = nbytes - 2; k >= nbytes - 1 - keep; k--) begin
			b = {2'b10, 6'(cp >> (6 * k))};
			if ($urandom_range(9) == 0)
				b[7:6] = 2'($urandom);
			put_byte(b, 1'b1, 1'b0);
		end
	endtask

	function automatic int bytes_for(input logic [CP_W-1:0] cp);
		if (cp < 21'h800)
			return 2;
		if (cp < 21'h10000)
			return 3;
		return 4;
	endfunction

	task automatic gen_text(input int n_cp);
		logic [CP_W-1:0] cp;
		int r;
		int n;
		int made;
		made = 0;
		for (int i = 0; i < n_cp; i++) begin
			r = $urandom_range(99);
			n = 0;
			if (r < 28) begin
				put_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b1, 1'b0);
			end else if (r < 33) begin
				put_byte($urandom_range(1) ? 8'h7F : 8'($urandom_range(31)), 1'b1, 1'b0);
			end else if (r < 43) begin
				cp = $urandom_range(1) ? CP_W'($urandom_range(CP_KANA_LO, CP_KANA_HI)) :
					CP_W'($urandom_range(CP_KANA_EXT_LO, CP_KANA_EXT_HI));
				n = 3;
			end else if (r < 53) begin
				cp = CP_W'($urandom_range(CP_CJK_LO, CP_CJK_HI));
				n = 3;
			end else if (r < 58) begin
				cp = CP_W'($urandom_range(CP_HWKANA_LO, CP_HWKANA_HI));
				n = 3;
			end else if (r < 61) begin
				cp = CP_REPLACEMENT;
				n = 3;
			end else if (r < 65) begin
				cp = CP_W'($urandom_range(CP_C1_LO, CP_C1_HI));
				n = 2;
			end else if (r < 71) begin
				cp = CP_W'($urandom_range(21'h7FF));
				n = 2;
			end else if (r < 77) begin
				cp = range_bounds[$urandom_range(12)] + CP_W'($urandom_range(2)) - 1'b1;
				if (cp < 21'h80 && $urandom_range(1))
					put_byte(cp[7:0], 1'b1, 1'b0);
				else
					n = bytes_for(cp);
			end else if (r < 81) begin
				cp = CP_W'($urandom_range(21'hFFFF));
				n = 3;
			end else if (r < 85) begin
				cp = CP_W'($urandom_range(21'h1FFFFF));
				n = 4;
			end else if (r < 89) begin
				put_byte($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF)) :
					8'($urandom_range(8'hF8, 8'hFF)), 1'b1, 1'b0);
			end else if (r < 92) begin
				put_byte(8'($urandom), 1'b1, 1'b0);
			end else if (r < 95) begin
				cp = CP_W'($urandom);
				n = $urandom_range(2, 4);
				put_code_point(cp, n, $urandom_range(n - 2));
				n = 0;
			end else begin
				put_byte(8'($urandom), 1'b0, 1'b0);
			end
			if (n != 0)
				put_code_point(cp, n, n - 1);
			made++;
		end
		if ($urandom_range(6) == 0) begin
			n = $urandom_range(2, 4);
			put_code_point(CP_W'($urandom), n, $urandom_range(n - 2));
			made++;
		end
		if (made != 0 && byte_queue.size() != 0 && byte_queue[$].byte_present &&
				$urandom_range(1))
			byte_queue[byte_queue.size() - 1].end_of_text = 1'b1;
		else
			put_byte(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain_scores;
		while (byte_queue.size() != 0 || in_ch.valid || score_queue.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.text_byte <= '0;
			in_ch.byte_present <= 1'b0;
			in_ch.end_of_text <= 1'b0;
			open_cp = '0;
			cont_left = 2'd0;
			run_score = '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				score_text_item(in_ch.text_byte, in_ch.byte_present, in_ch.end_of_text);
			if (!in_ch.valid || in_ch.ready) begin
				if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					in_ch.text_byte <= byte_queue[0].text_byte;
					in_ch.byte_present <= byte_queue[0].byte_present;
					in_ch.end_of_text <= byte_queue[0].end_of_text;
					void'(byte_queue.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			holds_served <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_served != holds_asked) begin
			hold_left <= 300;
			holds_served <= holds_served + 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (score_queue.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("final_score %0d arrived with no text closed", out_ch.final_score);
			end else if (out_ch.final_score !== score_queue[0]) begin
				errors++;
				if (errors <= 10)
					$display("final_score expected %0d, got %0d", score_queue[0],
						out_ch.final_score);
				void'(score_queue.pop_front());
			end else begin
				void'(score_queue.pop_front());
			end
		end
	end

	initial begin
		errors = 0;
		items_made = 0;
		holds_asked = 0;
		send_idle_pct = 14;
		recv_idle_pct = 73;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Empty text, then an idle item and single bytes at the extremes.
		put_byte(8'h00, 1'b0, 1'b1);
		put_byte(8'h55, 1'b0, 1'b0);
		put_byte(8'h20, 1'b1, 1'b0);
		put_byte(8'h7E, 1'b1, 1'b0);
		put_byte(8'h1F, 1'b1, 1'b0);
		put_byte(8'h00, 1'b1, 1'b0);
		put_byte(8'hFF, 1'b1, 1'b1);
		// C1 controls, a stray continuation byte and the replacement character.
		put_byte(8'hC2, 1'b1, 1'b0);
		put_byte(8'h80, 1'b1, 1'b0);
		put_byte(8'hC2, 1'b1, 1'b0);
		put_byte(8'h9F, 1'b1, 1'b0);
		put_byte(8'h80, 1'b1, 1'b0);
		put_byte(8'hEF, 1'b1, 1'b0);
		put_byte(8'hBF, 1'b1, 1'b0);
		put_byte(8'hBD, 1'b1, 1'b1);
		// A continuation without the 10 prefix, then a sequence cut short.
		put_byte(8'hC3, 1'b1, 1'b0);
		put_byte(8'h41, 1'b1, 1'b0);
		put_byte(8'hE3, 1'b1, 1'b0);
		put_byte(8'h81, 1'b1, 1'b1);
		// A four-byte lead closed by an end mark with no byte.
		put_byte(8'hF7, 1'b1, 1'b0);
		put_byte(8'hAA, 1'b0, 1'b1);
		// Kana, a CJK ideograph and halfwidth katakana.
		put_code_point(21'h3042, 3, 2);
		put_code_point(21'h4E00, 3, 2);
		put_byte(8'hEF, 1'b1, 1'b0);
		put_byte(8'hBD, 1'b1, 1'b0);
		put_byte(8'hA1, 1'b1, 1'b1);
		drain_scores();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 73 : 0;
			recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 14 : 0;
			items_made = 0;
			if (phase == 2) begin
				holds_asked++;
				for (int t = 0; t < 40; t++)
					gen_text($urandom_range(3));
			end
			while (items_made < 280)
				gen_text(($urandom_range(9) == 0) ? $urandom_range(40, 60) :
					$urandom_range(12));
			drain_scores();
		end

		repeat (20) @(posedge clk);
		if (errors == 0 && score_queue.size() == 0)
			$display("utf8_text_plausibility_scorer_core: match");
		else
			$display("utf8_text_plausibility_scorer_core: mismatch");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/utps_pkg.sv
hw/rtl/utps_in_if.sv
hw/rtl/utps_out_if.sv
hw/rtl/utps_decode.sv
hw/rtl/utps_accum.sv
hw/rtl/utf8_text_plausibility_scorer_core.sv
dv/utf8_text_plausibility_scorer_core_tb.sv
